[hw/rtl/hsfd_pkg.sv]
// Shared types, constants and CRC function for the humidity sensor frame decoder.
package hsfd_pkg;

    localparam logic [7:0]         CRC_INIT      = 8'hFF;
    localparam logic [7:0]         CRC_POLY      = 8'h31;
    localparam logic [14:0]        TEMP_SCALE    = 15'd17500;
    localparam logic signed [15:0] TEMP_BASE     = 16'sd4500;
    localparam logic [13:0]        HUM_SCALE     = 14'd10000;
    localparam logic signed [11:0] OFFSET_RESET  = -12'sd400;

    localparam logic               KIND_MEAS     = 1'b0;
    localparam logic               KIND_ID       = 1'b1;

    localparam logic [2:0]         POS_FIRST     = 3'd0;
    localparam logic [2:0]         POS_ID_LAST   = 3'd2;
    localparam logic [2:0]         POS_MEAS_LAST = 3'd5;

    typedef struct packed {
        logic       frame_start;
        logic       req_type;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic               frame_kind;
        logic               crc_error;
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic [15:0]        device_id;
    } result_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/humidity_sensor_frame_decoder.sv]
// Result path: a frame's last byte passes the input register, then the result register, before
// m_tvalid rises; a stalled m_tready adds its stall.
// Throughput: one byte per cycle while no result waits or m_tready is high; a waiting result
// holds the core, so only one more byte is taken into the input register until it drains.
// Reset: synchronous active-low aresetn returns frame position, CRC, error flag, kind
// and both valid flags to their idle values and loads the temperature offset with -400.
module humidity_sensor_frame_decoder
    import hsfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // rx_byte
    input  logic [1:0]  s_tuser,      // req_type, frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,      // temperature_centi, humidity_centi, device_id, zero pad
    output logic [1:0]  m_tuser,      // frame_kind, crc_error
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data
);

    logic               in_valid_reg;
    item_t              in_item_reg;
    logic               out_valid_reg;
    result_t            out_res_reg;
    logic signed [11:0] offset_reg;
    logic               advance;
    logic               res_valid;
    result_t            res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    hsfd_frame_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item        (in_item_reg),
        .temp_offset (offset_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            offset_reg    <= OFFSET_RESET;
        end else begin
            if (cfg_wr_en) begin
                offset_reg <= $signed(cfg_wr_data);
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= res_valid;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.rx_byte     <= s_tdata;
            in_item_reg.req_type    <= s_tuser[0];
            in_item_reg.frame_start <= s_tuser[1];
        end
        if (res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_res_reg.crc_error, out_res_reg.frame_kind};
    assign m_tdata  = {3'b000, out_res_reg.device_id, out_res_reg.humidity_centi,
                       out_res_reg.temperature_centi};

endmodule

[hw/rtl/hsfd_frame_core.sv]
// Frame position tracking, per-word CRC check and reading conversion.
module hsfd_frame_core
    import hsfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  item_t              item,
    input  logic signed [11:0] temp_offset,
    output logic               res_valid,
    output result_t            res
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  high_reg, high_next;
    logic [15:0] word_reg, word_next;
    logic [14:0] temp_scaled_reg, temp_scaled_next;
    logic [13:0] hum_reg, hum_next;
    logic        failed_reg, failed_next;
    logic        kind_reg, kind_next;

    logic               restart;
    logic               kind_eff;
    logic [2:0]         pos_eff;
    logic [7:0]         crc_eff;
    logic               failed_eff;
    logic               fail_now;
    logic [7:0]         crc_upd;
    logic [15:0]        word_w;
    logic [30:0]        temp_prod;
    logic [29:0]        hum_prod;
    logic signed [15:0] temp_sum;

    assign restart    = item.frame_start || (pos_reg > POS_MEAS_LAST);
    assign kind_eff   = item.frame_start ? item.req_type : kind_reg;
    assign pos_eff    = restart ? POS_FIRST : pos_reg;
    assign crc_eff    = restart ? CRC_INIT : crc_reg;
    assign failed_eff = restart ? 1'b0 : failed_reg;
    assign crc_upd    = crc8_byte(crc_eff, item.rx_byte);
    assign fail_now   = failed_eff || (crc_eff != item.rx_byte);
    assign word_w     = {high_reg, item.rx_byte};
    assign temp_prod  = 31'(word_w) * 31'(TEMP_SCALE);
    assign hum_prod   = 30'(word_w) * 30'(HUM_SCALE);
    assign temp_sum   = $signed({1'b0, temp_scaled_reg}) - TEMP_BASE
                        + 16'(temp_offset);

    always_comb begin
        pos_next         = pos_reg;
        crc_next         = crc_reg;
        high_next        = high_reg;
        word_next        = word_reg;
        temp_scaled_next = temp_scaled_reg;
        hum_next         = hum_reg;
        failed_next      = failed_eff;
        kind_next        = kind_eff;
        res_valid        = 1'b0;
        res              = '0;
        res.frame_kind   = kind_eff;
        res.crc_error    = fail_now;
        if (kind_eff == KIND_ID) begin
            res.device_id = word_reg;
        end else begin
            res.temperature_centi = temp_sum[14:0];
            res.humidity_centi    = hum_reg;
        end
        case (pos_eff) inside
            3'd0, 3'd3: begin
                high_next = item.rx_byte;
                crc_next  = crc_upd;
                pos_next  = pos_eff + 3'd1;
            end
            3'd1, 3'd4: begin
                if (pos_eff == 3'd1) begin
                    word_next        = word_w;
                    temp_scaled_next = temp_prod[30:16];
                end else begin
                    hum_next = hum_prod[29:16];
                end
                crc_next = crc_upd;
                pos_next = pos_eff + 3'd1;
            end
            default: begin
                crc_next    = CRC_INIT;
                failed_next = fail_now;
                if ((kind_eff == KIND_ID && pos_eff == POS_ID_LAST)
                    || pos_eff == POS_MEAS_LAST) begin
                    res_valid   = 1'b1;
                    pos_next    = POS_FIRST;
                    failed_next = 1'b0;
                end else begin
                    pos_next = pos_eff + 3'd1;
                end
            end
        endcase
        res_valid = res_valid && advance;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= POS_FIRST;
            crc_reg         <= CRC_INIT;
            high_reg        <= '0;
            word_reg        <= '0;
            temp_scaled_reg <= '0;
            hum_reg         <= '0;
            failed_reg      <= 1'b0;
            kind_reg        <= KIND_MEAS;
        end else if (advance) begin
            pos_reg         <= pos_next;
            crc_reg         <= crc_next;
            high_reg        <= high_next;
            word_reg        <= word_next;
            temp_scaled_reg <= temp_scaled_next;
            hum_reg         <= hum_next;
            failed_reg      <= failed_next;
            kind_reg        <= kind_next;
        end
    end

endmodule
